### hdl/bdre_pkg.sv
// Package for the binary delta run encoder: constants, codes and shared types.
package bdre_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam logic [15:0] GAP_LIMIT_RESET = 16'd4;

    localparam logic [1:0] REC_REPLACE  = 2'd0;
    localparam logic [1:0] REC_DEL_TAIL = 2'd1;
    localparam logic [1:0] REC_ADD_TAIL = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    typedef enum logic [1:0] {
        TAIL_NONE = 2'd0,
        TAIL_DEL  = 2'd1,
        TAIL_ADD  = 2'd2
    } t_tail;

    // One classified item: a record closed by the byte step, a data byte,
    // and a record closed by the final request, emitted in that order.
    typedef struct packed {
        logic        has_rec0;
        logic [31:0] rec0_offset;
        logic [31:0] rec0_length;
        logic        has_data;
        logic [7:0]  data_byte;
        logic        has_rec2;
        logic [31:0] rec2_offset;
        logic [31:0] rec2_length;
        logic [1:0]  rec2_type;
    } t_cmd;

    typedef struct packed {
        logic wr;
        t_cmd cmd;
    } t_push;

endpackage

### hdl/bdre_front.sv
// Front end: accepts compare items, tracks run and tail state, builds result commands.
module bdre_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_accept,
    input  logic            i_base_present,
    input  logic [7:0]      i_base_byte,
    input  logic            i_mod_present,
    input  logic [7:0]      i_mod_byte,
    input  logic            i_final_req,
    output bdre_pkg::t_push o_push
);

    logic                r_run_open, n_run_open;
    logic [15:0]         r_gap_count, n_gap_count;
    logic [31:0]         r_position, n_position;
    logic [31:0]         r_run_start, n_run_start;
    logic [31:0]         r_run_length, n_run_length;
    bdre_pkg::t_tail     r_tail, n_tail;
    logic [15:0]         r_gap_limit;
    bdre_pkg::t_cmd      cmd;

    always_comb begin
        n_run_open   = r_run_open;
        n_gap_count  = r_gap_count;
        n_position   = r_position;
        n_run_start  = r_run_start;
        n_run_length = r_run_length;
        n_tail       = r_tail;
        cmd          = '0;

        unique case (r_tail)
            bdre_pkg::TAIL_DEL: begin
                n_run_length = r_run_length + {31'd0, i_base_present};
                n_position   = r_position + {31'd0, i_base_present | i_mod_present};
            end
            bdre_pkg::TAIL_ADD: begin
                cmd.has_data  = i_mod_present;
                cmd.data_byte = i_mod_byte;
                n_run_length  = r_run_length + {31'd0, i_mod_present};
                n_position    = r_position + {31'd0, i_base_present | i_mod_present};
            end
            default: begin
                priority if (i_base_present && i_mod_present) begin
                    if (i_base_byte != i_mod_byte) begin
                        n_run_open    = 1'b1;
                        n_run_start   = r_run_open ? r_run_start : r_position;
                        n_run_length  = (r_run_open ? r_run_length : 32'd0) + 32'd1;
                        n_gap_count   = '0;
                        cmd.has_data  = 1'b1;
                        cmd.data_byte = i_mod_byte;
                    end else if (r_run_open) begin
                        if (r_gap_count >= r_gap_limit) begin
                            cmd.has_rec0    = 1'b1;
                            cmd.rec0_offset = r_run_start;
                            cmd.rec0_length = r_run_length;
                            n_run_open      = 1'b0;
                            n_run_length    = '0;
                            n_gap_count     = '0;
                        end else begin
                            n_gap_count   = r_gap_count + 16'd1;
                            n_run_length  = r_run_length + 32'd1;
                            cmd.has_data  = 1'b1;
                            cmd.data_byte = i_mod_byte;
                        end
                    end
                    n_position = r_position + 32'd1;
                end else if (i_base_present || i_mod_present) begin
                    cmd.has_rec0    = r_run_open;
                    cmd.rec0_offset = r_run_start;
                    cmd.rec0_length = r_run_length;
                    n_run_open      = 1'b0;
                    n_gap_count     = '0;
                    n_tail          = i_base_present ? bdre_pkg::TAIL_DEL
                                                     : bdre_pkg::TAIL_ADD;
                    n_run_start     = r_position;
                    n_run_length    = 32'd1;
                    n_position      = r_position + 32'd1;
                    cmd.has_data    = !i_base_present;
                    cmd.data_byte   = i_mod_byte;
                end else begin
                end
            end
        endcase

        if (i_final_req) begin
            cmd.has_rec2    = n_run_open || (n_tail != bdre_pkg::TAIL_NONE);
            cmd.rec2_offset = n_run_start;
            cmd.rec2_length = n_run_length;
            cmd.rec2_type   = n_run_open ? bdre_pkg::REC_REPLACE : n_tail;
            n_run_open      = 1'b0;
            n_gap_count     = '0;
            n_position      = '0;
            n_run_start     = '0;
            n_run_length    = '0;
            n_tail          = bdre_pkg::TAIL_NONE;
        end
        if (!cmd.has_data) begin
            cmd.data_byte = '0;
        end
    end

    assign o_push.wr  = i_accept && (cmd.has_rec0 || cmd.has_data || cmd.has_rec2);
    assign o_push.cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open   <= 1'b0;
            r_gap_count  <= '0;
            r_position   <= '0;
            r_run_start  <= '0;
            r_run_length <= '0;
            r_tail       <= bdre_pkg::TAIL_NONE;
            r_gap_limit  <= bdre_pkg::GAP_LIMIT_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_gap_limit <= i_cfg_data;
            end
            if (i_accept) begin
                r_run_open   <= n_run_open;
                r_gap_count  <= n_gap_count;
                r_position   <= n_position;
                r_run_start  <= n_run_start;
                r_run_length <= n_run_length;
                r_tail       <= n_tail;
            end
        end
    end

endmodule

### hdl/bdre_queue.sv
// Command queue between the front end and the result sequencer.
module bdre_queue #(
    parameter int unsigned DEPTH = bdre_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bdre_pkg::t_push i_push,
    input  logic            i_rd,
    output bdre_pkg::t_cmd  o_head,
    output logic            o_valid,
    output logic            o_full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    bdre_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           wr_en;
    logic           rd_en;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_head  = r_mem[r_rd_ptr];
    assign wr_en   = i_push.wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + PW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### hdl/bdre_back.sv
// Result sequencer: expands queued commands into one result per cycle while pop is high.
module bdre_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bdre_pkg::t_cmd i_head,
    input  logic           i_head_valid,
    output logic           o_head_rd,
    input  logic           pop,
    output logic           empty,
    output logic           o_kind,
    output logic [7:0]     o_data_byte,
    output logic [31:0]    o_rec_offset,
    output logic [31:0]    o_rec_length,
    output logic [1:0]     o_rec_type,
    output logic           o_last_of_item
);

    logic        r_valid;
    logic [2:0]  r_done;
    logic [2:0]  rem;
    logic [2:0]  sel;
    logic        last;
    logic        load;

    assign rem  = {i_head.has_rec2, i_head.has_data, i_head.has_rec0} & ~r_done;
    assign sel  = rem[0] ? 3'b001 : (rem[1] ? 3'b010 : 3'b100);
    assign last = ((rem & ~sel) == 3'b000);
    assign load = i_head_valid && (!r_valid || pop);
    assign o_head_rd = load && last;
    assign empty = !r_valid;

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_last_of_item <= last;
            unique case (sel)
                3'b001: begin
                    o_kind       <= bdre_pkg::KIND_RECORD;
                    o_data_byte  <= '0;
                    o_rec_offset <= i_head.rec0_offset;
                    o_rec_length <= i_head.rec0_length;
                    o_rec_type   <= bdre_pkg::REC_REPLACE;
                end
                3'b010: begin
                    o_kind       <= bdre_pkg::KIND_DATA;
                    o_data_byte  <= i_head.data_byte;
                    o_rec_offset <= '0;
                    o_rec_length <= '0;
                    o_rec_type   <= '0;
                end
                default: begin
                    o_kind       <= bdre_pkg::KIND_RECORD;
                    o_data_byte  <= '0;
                    o_rec_offset <= i_head.rec2_offset;
                    o_rec_length <= i_head.rec2_length;
                    o_rec_type   <= i_head.rec2_type;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_done  <= last ? 3'b000 : (r_done | sel);
            end else if (pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### hdl/binary_delta_run_encoder_unit.sv
// Top level of the binary delta run encoder.
// Takes one base/modified position per cycle while full is low; the item's
// run and tail state is updated in the same cycle and its results are
// queued as one command in a QUEUE_DEPTH-entry queue. Results leave one per
// cycle while pop is high, through a registered output fed from the queue
// head, so sustained rate is one item per cycle as long as pop stays high
// and items average at most one result; full rises when the command queue
// fills. Items that cause no result take no queue entry. gap_limit is
// written through the cfg channel, which is always ready and should be
// written only while the block is idle.
module binary_delta_run_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = bdre_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_base_present,
    input  logic [7:0]  i_base_byte,
    input  logic        i_mod_present,
    input  logic [7:0]  i_mod_byte,
    input  logic        i_final_req,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_rec_offset,
    output logic [31:0] o_rec_length,
    output logic [1:0]  o_rec_type,
    output logic        o_last_of_item
);

    bdre_pkg::t_push q_push;
    bdre_pkg::t_cmd  q_head;
    logic            q_valid;
    logic            q_rd;
    logic            accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    bdre_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_base_present (i_base_present),
        .i_base_byte    (i_base_byte),
        .i_mod_present  (i_mod_present),
        .i_mod_byte     (i_mod_byte),
        .i_final_req    (i_final_req),
        .o_push         (q_push)
    );

    bdre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rd    (q_rd),
        .o_head  (q_head),
        .o_valid (q_valid),
        .o_full  (full)
    );

    bdre_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_head_valid   (q_valid),
        .o_head_rd      (q_rd),
        .pop            (pop),
        .empty          (empty),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_rec_offset   (o_rec_offset),
        .o_rec_length   (o_rec_length),
        .o_rec_type     (o_rec_type),
        .o_last_of_item (o_last_of_item)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Testbench for binary_delta_run_encoder_unit: directed and random stream pairs, checked by a predictor.
module tb;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 80;
    localparam int LONG_HOLD    = 150;

    typedef struct packed {
        logic       bp;
        logic [7:0] bb;
        logic       mp;
        logic [7:0] mb;
        logic       fin;
    } t_pos_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [31:0] off;
        logic [31:0] len;
        logic [1:0]  rtype;
        logic        last;
    } t_patch_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        i_base_present = 1'b0;
    logic [7:0]  i_base_byte = '0;
    logic        i_mod_present = 1'b0;
    logic [7:0]  i_mod_byte = '0;
    logic        i_final_req = 1'b0;
    logic        pop = 1'b0;
    logic        o_cfg_ready;
    logic        full;
    logic        empty;
    logic        o_kind;
    logic [7:0]  o_data_byte;
    logic [31:0] o_rec_offset;
    logic [31:0] o_rec_length;
    logic [1:0]  o_rec_type;
    logic        o_last_of_item;

    t_pos_item   pos_q[$];
    t_patch_out  patch_q[$];
    int          errors = 0;
    int          stim_count = 0;
    int          res_seen = 0;
    int unsigned cycles = 0;
    bit          quiet = 1'b0;
    bit          in_taken = 1'b0;
    bit          cfg_taken = 1'b0;
    bit          hold_done = 1'b0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          rx_hold = 0;

    // predicted encoder state
    logic            p_run_open;
    logic [15:0]     p_gap_cnt;
    logic [15:0]     p_gap_limit;
    logic [31:0]     p_pos;
    logic [31:0]     p_run_start;
    logic [31:0]     p_run_len;
    bdre_pkg::t_tail p_tail;
    t_patch_out      step_res[3];
    int              step_n;

    binary_delta_run_encoder_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_base_present (i_base_present),
        .i_base_byte    (i_base_byte),
        .i_mod_present  (i_mod_present),
        .i_mod_byte     (i_mod_byte),
        .i_final_req    (i_final_req),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_rec_offset   (o_rec_offset),
        .o_rec_length   (o_rec_length),
        .o_rec_type     (o_rec_type),
        .o_last_of_item (o_last_of_item)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic void clear_encoder();
        p_run_open  = 1'b0;
        p_gap_cnt   = '0;
        p_pos       = '0;
        p_run_start = '0;
        p_run_len   = '0;
        p_tail      = bdre_pkg::TAIL_NONE;
    endfunction

    function automatic void emit(logic kind, logic [7:0] d, logic [31:0] off,
                                 logic [31:0] len, logic [1:0] rtype);
        step_res[step_n] = '{kind, d, off, len, rtype, 1'b0};
        step_n++;
    endfunction

    function automatic void close_run();
        if (p_run_open) begin
            emit(bdre_pkg::KIND_RECORD, 8'd0, p_run_start, p_run_len, bdre_pkg::REC_REPLACE);
            p_run_open = 1'b0;
            p_run_len  = '0;
            p_gap_cnt  = '0;
        end
    endfunction

    function automatic void encode_position(t_pos_item it);
        step_n = 0;
        case (p_tail)
            bdre_pkg::TAIL_DEL: begin
                if (it.bp) p_run_len++;
                if (it.bp || it.mp) p_pos++;
            end
            bdre_pkg::TAIL_ADD: begin
                if (it.mp) begin
                    emit(bdre_pkg::KIND_DATA, it.mb, '0, '0, bdre_pkg::REC_REPLACE);
                    p_run_len++;
                end
                if (it.bp || it.mp) p_pos++;
            end
            default: begin
                if (it.bp && it.mp) begin
                    if (it.bb != it.mb) begin
                        if (!p_run_open) begin
                            p_run_open  = 1'b1;
                            p_run_start = p_pos;
                            p_run_len   = '0;
                        end
                        p_gap_cnt = '0;
                        emit(bdre_pkg::KIND_DATA, it.mb, '0, '0, bdre_pkg::REC_REPLACE);
                        p_run_len++;
                    end else if (p_run_open) begin
                        if (p_gap_cnt >= p_gap_limit) begin
                            close_run();
                        end else begin
                            p_gap_cnt++;
                            p_run_len++;
                            emit(bdre_pkg::KIND_DATA, it.mb, '0, '0, bdre_pkg::REC_REPLACE);
                        end
                    end
                    p_pos++;
                end else if (it.bp || it.mp) begin
                    close_run();
                    p_tail      = it.bp ? bdre_pkg::TAIL_DEL : bdre_pkg::TAIL_ADD;
                    p_run_start = p_pos;
                    p_run_len   = 32'd1;
                    if (!it.bp)
                        emit(bdre_pkg::KIND_DATA, it.mb, '0, '0, bdre_pkg::REC_REPLACE);
                    p_pos++;
                end
            end
        endcase
        if (it.fin) begin
            close_run();
            if (p_tail != bdre_pkg::TAIL_NONE) begin
                emit(bdre_pkg::KIND_RECORD, 8'd0, p_run_start, p_run_len,
                     (p_tail == bdre_pkg::TAIL_DEL) ? bdre_pkg::REC_DEL_TAIL
                                                    : bdre_pkg::REC_ADD_TAIL);
            end
            clear_encoder();
        end
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (int k = 0; k < step_n; k++) patch_q.push_back(step_res[k]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void add_pos(logic bp, logic [7:0] bb, logic mp, logic [7:0] mb,
                                    logic fin);
        pos_q.push_back('{bp, bb, mp, mb, fin});
        if (bp || mp || fin) stim_count++;
    endfunction

    function automatic void add_noise();
        add_pos(1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                $urandom_range(0, 7) == 0);
    endfunction

    // one base/modified file pair: common part, optional tail, closing request
    function automatic void add_stream_pair();
        int         common_len;
        int         tail_len;
        int         mism_pct;
        bit         add_tail;
        logic [7:0] b;
        common_len = $urandom_range(0, 24);
        tail_len   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        add_tail   = 1'($urandom);
        mism_pct   = $urandom_range(5, 60);
        for (int k = 0; k < common_len; k++) begin
            b = 8'($urandom);
            if ($urandom_range(0, 99) < mism_pct)
                add_pos(1'b1, b, 1'b1, b ^ 8'($urandom_range(1, 255)), 1'b0);
            else
                add_pos(1'b1, b, 1'b1, b, 1'b0);
            if ($urandom_range(0, 19) == 0)
                add_pos(1'b0, 8'($urandom), 1'b0, 8'($urandom), 1'b0);
        end
        for (int k = 0; k < tail_len; k++) begin
            case ($urandom_range(0, 9))
                0: add_pos(1'b1, 8'($urandom), 1'b1, 8'($urandom), 1'b0);
                1: add_pos(add_tail, 8'($urandom), !add_tail, 8'($urandom), 1'b0);
                2: add_pos(1'b0, 8'($urandom), 1'b0, 8'($urandom), 1'b0);
                default: add_pos(!add_tail, 8'($urandom), add_tail, 8'($urandom), 1'b0);
            endcase
        end
        case ($urandom_range(0, 2))
            0: add_pos(1'b0, 8'($urandom), 1'b0, 8'($urandom), 1'b1);
            1: begin
                if (tail_len > 0)
                    add_pos(!add_tail, 8'($urandom), add_tail, 8'($urandom), 1'b1);
                else
                    add_pos(1'b1, 8'($urandom), 1'b1, 8'($urandom), 1'b1);
            end
            default: add_pos(1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom), 1'b1);
        endcase
    endfunction

    task automatic wait_idle();
        while (pos_q.size() != 0 || push || patch_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gap_limit(input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // result check, request prediction, config tracking, timeout
    always @(posedge i_clk) begin : mon
        t_patch_out want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (pop && !empty) begin
                res_seen++;
                if (patch_q.size() == 0) begin
                    $error("unexpected result: kind %0d data %0h", o_kind, o_data_byte);
                    errors++;
                end else begin
                    want = patch_q.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("data_byte", want.data, o_data_byte);
                    check_field("rec_offset", want.off, o_rec_offset);
                    check_field("rec_length", want.len, o_rec_length);
                    check_field("rec_type", want.rtype, o_rec_type);
                    check_field("last_of_item", want.last, o_last_of_item);
                end
            end
            if (push && !full)
                encode_position('{i_base_present, i_base_byte, i_mod_present, i_mod_byte,
                                   i_final_req});
            if (i_cfg_valid && o_cfg_ready) p_gap_limit = i_cfg_data;
        end
        in_taken  <= i_rst_n && push && !full;
        cfg_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
    end

    // request driver
    always @(negedge i_clk) begin : drv
        t_pos_item it;
        if (!i_rst_n || (push && !in_taken)) begin
            // hold current request
        end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            push   <= 1'b0;
        end else if (pos_q.size() == 0) begin
            push <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            tx_gap <= $urandom_range(0, 17);
            push   <= 1'b0;
        end else begin
            it = pos_q.pop_front();
            push           <= 1'b1;
            i_base_present <= it.bp;
            i_base_byte    <= it.bb;
            i_mod_present  <= it.mp;
            i_mod_byte     <= it.mb;
            i_final_req    <= it.fin;
        end
    end

    // result receiver; one long hold-off lets the block fill up
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            pop     <= 1'b0;
        end else if (!hold_done && res_seen >= 40) begin
            hold_done <= 1'b1;
            rx_hold   <= LONG_HOLD;
            pop       <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            pop    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 17);
            pop    <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    initial begin
        logic [15:0] phase_gaps[5];
        clear_encoder();
        p_gap_limit = bdre_pkg::GAP_LIMIT_RESET;
        phase_gaps  = '{16'd0, 16'hFFFF, 16'd1, 16'd2, 16'($urandom_range(0, 6))};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset gap limit
        add_pos(1'b1, 8'h00, 1'b1, 8'h00, 1'b0);
        add_pos(1'b1, 8'h00, 1'b1, 8'hFF, 1'b0);
        add_pos(1'b1, 8'hFF, 1'b1, 8'h00, 1'b0);
        repeat (4) add_pos(1'b1, 8'h5A, 1'b1, 8'h5A, 1'b0);
        add_pos(1'b1, 8'hA5, 1'b1, 8'hA5, 1'b0);
        add_pos(1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
        add_pos(1'b1, 8'h12, 1'b1, 8'h34, 1'b0);
        add_pos(1'b0, 8'hFF, 1'b0, 8'hFF, 1'b1);
        add_pos(1'b1, 8'h80, 1'b1, 8'h01, 1'b0);
        add_pos(1'b1, 8'h77, 1'b0, 8'h00, 1'b0);
        add_pos(1'b1, 8'h11, 1'b1, 8'h22, 1'b0);
        add_pos(1'b0, 8'h00, 1'b1, 8'h33, 1'b0);
        add_pos(1'b1, 8'hFF, 1'b0, 8'h00, 1'b1);
        add_pos(1'b0, 8'h00, 1'b1, 8'hAB, 1'b0);
        add_pos(1'b1, 8'hCD, 1'b1, 8'hEF, 1'b0);
        add_pos(1'b1, 8'h99, 1'b0, 8'h00, 1'b0);
        add_pos(1'b0, 8'h00, 1'b0, 8'h00, 1'b0);
        add_pos(1'b0, 8'h00, 1'b1, 8'hFF, 1'b1);
        add_pos(1'b1, 8'h01, 1'b1, 8'h02, 1'b0);
        add_pos(1'b0, 8'h00, 1'b1, 8'h7F, 1'b1);
        add_pos(1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1);
        add_pos(1'b1, 8'h3C, 1'b1, 8'hC3, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            quiet = (ph == 4);
            write_gap_limit(phase_gaps[ph]);
            stim_count = 0;
            while (stim_count < PHASE_ITEMS) begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 6)) add_noise();
                else
                    add_stream_pair();
            end
            wait_idle();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
